[src/red_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_pkg: shared types and constants of the rotary encoder decoder
// Transition tables, register indexes, divider sizing and state codes.
// ----------------------------------------------------------------------------
package red_pkg;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSITIVITY = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_MULTIPLIER = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_STEP = 2'd3;

  // register reset values
  localparam logic [7:0] SENSITIVITY_RESET = 8'd120;
  localparam logic [6:0] MAX_MULT_RESET = 7'd6;

  // minimum detent gap in ms
  localparam logic [7:0] MIN_GAP = 8'd3;

  // divider: 8-bit dividend, one quotient bit per step
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  // table entry: [4] counterclockwise, [3] clockwise, [2:0] next state
  typedef logic [4:0] entry_t;
  localparam entry_t E_CW = 5'h08;
  localparam entry_t E_CCW = 5'h10;

  localparam entry_t FULL_TABLE [8][4] = '{
    '{5'd0, 5'd2, 5'd4, 5'd0},
    '{5'd3, 5'd0, 5'd1, 5'd0 | E_CW},
    '{5'd3, 5'd2, 5'd0, 5'd0},
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd6, 5'd0, 5'd4, 5'd0},
    '{5'd6, 5'd5, 5'd0, 5'd0 | E_CCW},
    '{5'd6, 5'd5, 5'd4, 5'd0},
    '{5'd0, 5'd2, 5'd4, 5'd0}
  };

  localparam entry_t HALF_TABLE [8][4] = '{
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd3 | E_CCW, 5'd0, 5'd1, 5'd0},
    '{5'd3 | E_CW, 5'd2, 5'd0, 5'd0},
    '{5'd3, 5'd5, 5'd4, 5'd0},
    '{5'd3, 5'd3, 5'd4, 5'd0 | E_CW},
    '{5'd3, 5'd5, 5'd3, 5'd0 | E_CCW},
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd3, 5'd2, 5'd1, 5'd0}
  };

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

[src/red_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_if: handshake channels of the rotary encoder decoder
// Sample input, movement output and configuration write channels.
// ----------------------------------------------------------------------------

// pin sample word
interface red_sample_if #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 pin_a;
  logic                 pin_b;
  logic [TIME_BITS-1:0] time_ms;

  modport source (output valid, pin_a, pin_b, time_ms, input ready);
  modport sink (input valid, pin_a, pin_b, time_ms, output ready);
endinterface

// movement result word
interface red_result_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] movement;

  modport source (output valid, movement, input ready);
  modport sink (input valid, movement, output ready);
endinterface

// configuration write word
interface red_cfg_if;
  import red_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/rotary_encoder_accel_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// A sample is accepted in the idle state and its result is loaded into the output register
// from ST_DONE; a detent scaled by acceleration passes ST_SCALE for a gap over 255 ms, else
// the 8-step divider and then ST_SCALE. The next sample is taken while the previous result
// waits in the output register.
// Reset (rst, synchronous, active high) loads register defaults, start state,
// zero detent time and an empty output register.
// ----------------------------------------------------------------------------
// rotary_encoder_accel_decoder: quadrature decoder with speed acceleration
// Table-driven detent decode, with an iterative divider for the step scale.
// ----------------------------------------------------------------------------
module rotary_encoder_accel_decoder
  import red_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  red_sample_if.sink sample,
  red_result_if.source result,
  red_cfg_if.sink    cfg
);

  // configuration registers
  logic       accel_enable;
  logic [7:0] sensitivity;
  logic [6:0] max_multiplier;
  logic       half_step;

  // decoder state
  state_t               state;
  logic [2:0]           decode_state;
  logic [TIME_BITS-1:0] last_detent_time;

  // divider and result holding
  logic [7:0]              divisor;
  logic [7:0]              rem;
  logic [7:0]              quot;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    dir_cw;
  logic signed [7:0]       res;

  // output register
  logic              out_valid;
  logic signed [7:0] out_movement;

  logic sample_fire;
  logic cfg_fire;
  logic out_load;

  assign sample.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign sample_fire = sample.valid && sample.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  assign result.valid = out_valid;
  assign result.movement = out_movement;

  // table lookup
  logic [1:0] level;
  entry_t     entry;
  logic       det_cw;
  logic       det_ccw;

  always_comb begin
    level = {sample.pin_b, sample.pin_a};
    entry = half_step ? HALF_TABLE[decode_state][level] : FULL_TABLE[decode_state][level];
    det_cw = entry[3];
    det_ccw = !entry[3] && entry[4];
  end

  // detent gap
  logic [TIME_BITS-1:0] gap;
  logic                 gap_wide;
  logic                 gap_short;

  always_comb begin
    gap = sample.time_ms - last_detent_time;
    gap_wide = |gap[TIME_BITS-1:8];
    gap_short = !gap_wide && (gap[7:0] < MIN_GAP);
  end

  // one restoring division step
  logic [8:0] shifted;
  logic [9:0] diff;
  logic [7:0] rem_next;
  logic [7:0] quot_next;

  always_comb begin
    shifted = {rem, quot[7]};
    diff = {1'b0, shifted} - {2'b00, divisor};
    rem_next = diff[9] ? shifted[7:0] : diff[7:0];
    quot_next = {quot[6:0], !diff[9]};
  end

  // multiplier clamp and sign
  logic [7:0]        fac_lo;
  logic [7:0]        fac;
  logic signed [7:0] scaled;

  always_comb begin
    fac_lo = (quot == 8'd0) ? 8'd1 : quot;
    fac = (fac_lo > {1'b0, max_multiplier}) ? {1'b0, max_multiplier} : fac_lo;
    scaled = dir_cw ? -$signed(fac) : $signed(fac);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_enable <= 1'b0;
      sensitivity <= SENSITIVITY_RESET;
      max_multiplier <= MAX_MULT_RESET;
      half_step <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        REG_ACCEL_ENABLE:   accel_enable <= cfg.data[0];
        REG_SENSITIVITY:    sensitivity <= cfg.data;
        REG_MAX_MULTIPLIER: max_multiplier <= cfg.data[6:0];
        REG_HALF_STEP:      half_step <= cfg.data[0];
        default:            ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      decode_state <= 3'd0;
      last_detent_time <= '0;
      cnt <= '0;
    end else begin
      if (cfg_fire && cfg.index == REG_HALF_STEP) begin
        decode_state <= 3'd0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_fire) begin
            decode_state <= entry[2:0];
            dir_cw <= det_cw;
            if ((det_cw || det_ccw) && accel_enable) begin
              last_detent_time <= sample.time_ms;
              if (gap_short) begin
                res <= 8'sd0;
                state <= ST_DONE;
              end else if (gap_wide) begin
                quot <= 8'd0;
                state <= ST_SCALE;
              end else begin
                divisor <= gap[7:0];
                rem <= 8'd0;
                quot <= sensitivity;
                cnt <= '0;
                state <= ST_DIV;
              end
            end else begin
              res <= det_cw ? -8'sd1 : (det_ccw ? 8'sd1 : 8'sd0);
              state <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quot <= quot_next;
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          res <= scaled;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_movement <= res;
    end
  end

endmodule
`default_nettype wire

[verif/rotary_encoder_accel_decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_accel_decoder_checker: movement scoreboard
// Watches the sample, result and config words of the decoder. Runs its own
// copy of the quadrature tables, the detent timer and the acceleration
// scaling, and compares every result word in order against the prediction.
// ----------------------------------------------------------------------------
module rotary_encoder_accel_decoder_checker
  import red_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  input  logic                     sample_ready,
  input  logic                     pin_a,
  input  logic                     pin_b,
  input  logic [TIME_BITS-1:0]     time_ms,
  input  logic                     result_valid,
  input  logic                     result_ready,
  input  logic signed [7:0]        movement,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       checked,
  output int                       detents
);

  localparam int MAX_REPORTS = 10;
  localparam int SHORT_GAP_MS = 3;

  // table entry layout: [4] counterclockwise, [3] clockwise, [2:0] next state
  localparam logic [4:0] TURN_CW = 5'b01000;
  localparam logic [4:0] TURN_CCW = 5'b10000;

  localparam logic [4:0] FULL_ROWS [8][4] = '{
    '{5'd0, 5'd2, 5'd4, 5'd0},
    '{5'd3, 5'd0, 5'd1, TURN_CW},
    '{5'd3, 5'd2, 5'd0, 5'd0},
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd6, 5'd0, 5'd4, 5'd0},
    '{5'd6, 5'd5, 5'd0, TURN_CCW},
    '{5'd6, 5'd5, 5'd4, 5'd0},
    '{5'd0, 5'd2, 5'd4, 5'd0}
  };

  localparam logic [4:0] HALF_ROWS [8][4] = '{
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd3 | TURN_CCW, 5'd0, 5'd1, 5'd0},
    '{5'd3 | TURN_CW, 5'd2, 5'd0, 5'd0},
    '{5'd3, 5'd5, 5'd4, 5'd0},
    '{5'd3, 5'd3, 5'd4, TURN_CW},
    '{5'd3, 5'd5, 5'd3, TURN_CCW},
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd3, 5'd2, 5'd1, 5'd0}
  };

  // predicted register and decoder state
  logic                 accel_on;
  logic [7:0]           sens;
  logic [6:0]           mult_cap;
  logic                 half_mode;
  logic [2:0]           phase_state;
  logic [TIME_BITS-1:0] last_detent_ms;

  logic signed [7:0] due_movement [$];
  logic signed [7:0] want;

  // one sample word through the table, timer and scaling
  task automatic advance_decoder(input logic a, input logic b,
                                 input logic [TIME_BITS-1:0] now,
                                 output logic signed [7:0] steps);
    logic [1:0]           level;
    logic [4:0]           entry;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] factor;
    int                   turn;
    level = {b, a};
    entry = half_mode ? HALF_ROWS[phase_state][level] : FULL_ROWS[phase_state][level];
    phase_state = entry[2:0];
    turn = entry[3] ? -1 : (entry[4] ? 1 : 0);
    if (turn != 0 && accel_on) begin
      gap = now - last_detent_ms;
      last_detent_ms = now;
      if (gap < SHORT_GAP_MS) begin
        turn = 0;
      end else begin
        factor = sens;
        factor = factor / gap;
        if (factor < 1) factor = 1;
        if (factor > mult_cap) factor = mult_cap;
        turn = turn * int'(factor);
      end
    end
    steps = turn[7:0];
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      accel_on = 1'b0;
      sens = 8'd120;
      mult_cap = 7'd6;
      half_mode = 1'b0;
      phase_state = 3'd0;
      last_detent_ms = '0;
      due_movement.delete();
      errors = 0;
      checked = 0;
      detents = 0;
    end else begin
      // result word against the oldest prediction
      if (result_valid && result_ready) begin
        if (due_movement.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("checker: movement word %0d with no sample waiting at %0t",
                     movement, $realtime);
          errors++;
        end else begin
          want = due_movement.pop_front();
          checked++;
          if (movement !== want) begin
            if (errors < MAX_REPORTS)
              $display("checker: movement mismatch on word %0d: expected %0d got %0d",
                       checked, want, movement);
            errors++;
          end
        end
      end
      // config word
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_ENABLE: accel_on = cfg_data[0];
          REG_SENSITIVITY: sens = cfg_data;
          REG_MAX_MULTIPLIER: mult_cap = cfg_data[6:0];
          REG_HALF_STEP: begin
            half_mode = cfg_data[0];
            // a mode write always restarts the decode
            phase_state = 3'd0;
          end
          default: ;
        endcase
      end
      // sample word
      if (sample_valid && sample_ready) begin
        advance_decoder(pin_a, pin_b, time_ms, want);
        due_movement.push_back(want);
        if (want != 0) detents++;
      end
    end
    pending = due_movement.size();
  end

endmodule

[verif/rotary_encoder_accel_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_accel_decoder_tb: decoder testbench top
// Drives directed detents and random quadrature walks with random timing
// through several register settings, stalls both sides in bursts, and
// reports the verdict from the movement checker.
// ----------------------------------------------------------------------------
module rotary_encoder_accel_decoder_tb;
  import red_pkg::*;

  localparam int TIME_BITS = 32;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 165;
  localparam int DRAIN_CYCLES = 24;
  localparam int STEP_CW = 1;
  localparam int STEP_CCW = -1;

  // gray ring of levels {b,a}; walking forward turns clockwise
  localparam logic [1:0] RING [4] = '{2'd3, 2'd1, 2'd0, 2'd2};

  logic clk;
  logic rst;

  red_sample_if #(.TIME_BITS(TIME_BITS)) smp_bus ();
  red_result_if res_bus ();
  red_cfg_if cfg_bus ();

  int errors;
  int pending;
  int checked;
  int detents;

  bit                   calm;
  int                   ring_pos;
  int                   walk_dir;
  int                   stall_left;
  int                   sent;
  int                   settings;
  logic [TIME_BITS-1:0] now_ms;

  rotary_encoder_accel_decoder #(.TIME_BITS(TIME_BITS)) DUT (
    .clk   (clk),
    .rst   (rst),
    .sample(smp_bus),
    .result(res_bus),
    .cfg   (cfg_bus)
  );

  rotary_encoder_accel_decoder_checker #(.TIME_BITS(TIME_BITS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(smp_bus.valid),
    .sample_ready(smp_bus.ready),
    .pin_a       (smp_bus.pin_a),
    .pin_b       (smp_bus.pin_b),
    .time_ms     (smp_bus.time_ms),
    .result_valid(res_bus.valid),
    .result_ready(res_bus.ready),
    .movement    (res_bus.movement),
    .cfg_valid   (cfg_bus.valid),
    .cfg_ready   (cfg_bus.ready),
    .cfg_index   (cfg_bus.index),
    .cfg_data    (cfg_bus.data),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .detents     (detents)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: ready with random stall bursts
  initial begin
    res_bus.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        res_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready = 1'b0;
      end else if ($urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(1, 12) - 1;
        res_bus.ready = 1'b0;
      end else begin
        res_bus.ready = 1'b1;
      end
    end
  end

  // one sample word, with an occasional idle burst ahead of it
  task automatic send_sample(input logic [1:0] level, input logic [TIME_BITS-1:0] t);
    if (!calm && $urandom_range(0, 99) < 15) begin
      smp_bus.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    smp_bus.valid = 1'b1;
    smp_bus.pin_a = level[0];
    smp_bus.pin_b = level[1];
    smp_bus.time_ms = t;
    do @(posedge clk); while (!smp_bus.ready);
    @(negedge clk);
    sent++;
  endtask

  // one config word
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // drain, then write all four registers; unused data bits are random
  task automatic apply_settings(input logic accel, input logic [7:0] sens,
                                input logic [6:0] cap, input logic half);
    smp_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_write(REG_ACCEL_ENABLE, {7'($urandom), accel});
    cfg_write(REG_SENSITIVITY, sens);
    cfg_write(REG_MAX_MULTIPLIER, {1'($urandom), cap});
    cfg_write(REG_HALF_STEP, {7'($urandom), half});
    settings++;
  endtask

  // four gray steps in one direction, all stamped with the same time
  task automatic turn_detent(input int dir, input logic [TIME_BITS-1:0] t);
    repeat (4) begin
      ring_pos = (ring_pos + dir) & 3;
      send_sample(RING[ring_pos], t);
    end
  endtask

  // mostly a walk around the ring, with bounces, repeats and jumps
  task automatic random_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) walk_dir = -walk_dir;
    if (pick < 75) ring_pos = (ring_pos + walk_dir) & 3;
    else if (pick >= 93) ring_pos = $urandom_range(0, 3);
    else if (pick >= 85) ring_pos = (ring_pos - walk_dir) & 3;
    // time moves slowly most of the time so that short gaps occur
    pick = $urandom_range(0, 99);
    if (pick >= 97) now_ms = $urandom();
    else if (pick >= 90) now_ms = now_ms + $urandom_range(0, 300);
    else if (pick >= 75) now_ms = now_ms + $urandom_range(0, 30);
    else if (pick >= 40) now_ms = now_ms + $urandom_range(1, 2);
    send_sample(RING[ring_pos], now_ms);
  endtask

  // stimulus and verdict
  initial begin
    rst = 1'b1;
    smp_bus.valid = 1'b0;
    smp_bus.pin_a = 1'b1;
    smp_bus.pin_b = 1'b1;
    smp_bus.time_ms = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_ACCEL_ENABLE;
    cfg_bus.data = '0;
    calm = 1'b0;
    ring_pos = 0;
    walk_dir = STEP_CW;
    sent = 0;
    settings = 0;
    now_ms = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: plain detents, time at both extremes, level jumps
    turn_detent(STEP_CW, '0);
    turn_detent(STEP_CCW, '1);
    ring_pos = 2;
    send_sample(RING[ring_pos], '0);
    ring_pos = 0;
    send_sample(RING[ring_pos], '1);

    // acceleration: long gap, gap of exactly 3 across the wrap, short gap
    apply_settings(1'b1, 8'd120, 7'd6, 1'b0);
    turn_detent(STEP_CW, 32'hFFFF_FFFE);
    turn_detent(STEP_CCW, 32'd1);
    turn_detent(STEP_CW, 32'd2);
    now_ms = 32'd2;

    // random walks under a series of settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: apply_settings(1'b1, 8'd255, 7'd127, 1'b0);
        2: apply_settings(1'b1, 8'd0, 7'd1, 1'b1);
        3: apply_settings(1'b1, 8'd255, 7'd0, 1'b1);
        4: apply_settings(1'b0, 8'd0, 7'd127, 1'b1);
        default: begin
          apply_settings($urandom_range(0, 99) < 80, 8'($urandom),
                         $urandom_range(0, 1) ? 7'($urandom_range(0, 8)) : 7'($urandom),
                         1'($urandom));
        end
      endcase
      if (ph == RANDOM_PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) random_sample();
    end

    // drain and give the verdict
    smp_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d sample words under %0d register settings", sent, settings);
    $display("  %0d movement words compared, %0d of them detents", checked, detents);
    if (errors == 0 && pending == 0) begin
      $display("rotary_encoder_accel_decoder_tb: PASS");
    end else begin
      $display("rotary_encoder_accel_decoder_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("rotary_encoder_accel_decoder_tb: FAIL");
    $finish;
  end

endmodule

[sim.f]
src/red_pkg.sv
src/red_if.sv
src/rotary_encoder_accel_decoder.sv
verif/rotary_encoder_accel_decoder_checker.sv
verif/rotary_encoder_accel_decoder_tb.sv
